>>> hdl/htfd_pkg.sv
package htfd_pkg;

    // Frame byte positions
    localparam logic [2:0] PosTempHi  = 3'd0;
    localparam logic [2:0] PosTempLo  = 3'd1;
    localparam logic [2:0] PosTempCrc = 3'd2;
    localparam logic [2:0] PosHumHi   = 3'd3;
    localparam logic [2:0] PosHumLo   = 3'd4;
    localparam logic [2:0] PosHumCrc  = 3'd5;

    // CRC-8, MSB first
    localparam logic [7:0] CrcPoly = 8'h31;
    localparam logic [7:0] CrcInit = 8'hFF;

    // Scaling constants (raw full scale is 2^16 - 1)
    localparam int unsigned FullScaleBits = 16;
    localparam logic [10:0] TempScale  = 11'd1750;
    localparam logic [11:0] TempOffset = 12'd450;
    localparam logic [9:0]  HumScale   = 10'd1000;
    localparam int unsigned ProdWidth  = 27;

    // Status codes
    localparam logic StatusOk       = 1'b0;
    localparam logic StatusCrcError = 1'b1;

    // Raw frame handed to the scaling stage
    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        logic        crc_failed;
    } frame_raw_t;

    // One byte through the CRC register
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 65535^2: (x + (x >> 16) + 1) >> 16
    function automatic logic [10:0] div_full_scale(input logic [ProdWidth-1:0] x);
        logic [ProdWidth:0] s;
        s = {1'b0, x} + (ProdWidth+1)'(x >> FullScaleBits) + (ProdWidth+1)'(1);
        return 11'(s >> FullScaleBits);
    endfunction

endpackage

>>> hdl/htfd_frame.sv
module htfd_frame
    import htfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic        in_start,
    output logic        in_ready,
    output logic        res_valid,
    input  logic        res_ready,
    output frame_raw_t  res
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] hum_reg, hum_next;
    logic        fail_reg, fail_next;
    logic        res_valid_reg;
    frame_raw_t  res_reg, res_next;

    logic [2:0] pos_eff;
    logic       is_final;
    logic       fire;
    logic       done;

    // Effective position: start flag or an unreachable code restarts the frame
    assign pos_eff  = (in_start || pos_reg > PosHumCrc) ? PosTempHi : pos_reg;
    assign is_final = (pos_eff == PosHumCrc);
    assign in_ready = !is_final || !res_valid_reg || res_ready;
    assign fire     = in_valid && in_ready;
    assign done     = fire && is_final;

    // Per-byte frame update
    always_comb begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        temp_next = temp_reg;
        hum_next  = hum_reg;
        fail_next = fail_reg;
        res_next  = res_reg;
        if (fire) begin
            pos_next = pos_eff + 3'd1;
            case (pos_eff)
                PosTempHi: begin
                    fail_next = 1'b0;
                    crc_next  = crc8_feed(CrcInit, in_byte);
                    temp_next = {in_byte, 8'h00};
                end
                PosTempLo: begin
                    crc_next  = crc8_feed(crc_reg, in_byte);
                    temp_next = {temp_reg[15:8], in_byte};
                end
                PosTempCrc: begin
                    if (in_byte != crc_reg) begin
                        fail_next = 1'b1;
                    end
                end
                PosHumHi: begin
                    crc_next = crc8_feed(CrcInit, in_byte);
                    hum_next = {in_byte, 8'h00};
                end
                PosHumLo: begin
                    crc_next = crc8_feed(crc_reg, in_byte);
                    hum_next = {hum_reg[15:8], in_byte};
                end
                default: begin
                    pos_next             = PosTempHi;
                    fail_next            = fail_reg || (in_byte != crc_reg);
                    res_next.temp_word   = temp_reg;
                    res_next.hum_word    = hum_reg;
                    res_next.crc_failed  = fail_reg || (in_byte != crc_reg);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= PosTempHi;
            crc_reg       <= CrcInit;
            temp_reg      <= '0;
            hum_reg       <= '0;
            fail_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            temp_reg <= temp_next;
            hum_reg  <= hum_next;
            fail_reg <= fail_next;
            if (done) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Position never leaves the six-byte frame
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= PosHumCrc)
        else $error("frame position out of range");

    // A completed frame always presents a raw result
    a_done_result: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> res_valid)
        else $error("completed frame produced no result");

    // Non-final bytes advance the position by one
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !is_final) |=> (pos_reg == $past(pos_eff) + 3'd1))
        else $error("frame position did not advance");

endmodule

>>> hdl/htfd_scale.sv
module htfd_scale
    import htfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        res_valid,
    output logic        res_ready,
    input  frame_raw_t  res,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // [11:0] temperature_tenths, [21:12] humidity_tenths
    output logic [0:0]  m_tuser   // [0] status
);

    logic        valid_reg;
    logic [11:0] temp_reg, temp_next;
    logic [9:0]  hum_reg, hum_next;
    logic        status_reg, status_next;

    logic [ProdWidth-1:0] temp_prod;
    logic [ProdWidth-1:0] hum_prod;
    logic [10:0]          temp_q;
    logic [10:0]          hum_q;

    assign res_ready = !valid_reg || m_tready;

    // Scale raw words: value * k / 65535, truncating; a CRC failure gives zeros
    always_comb begin
        temp_prod = ProdWidth'(res.temp_word) * ProdWidth'(TempScale);
        hum_prod  = ProdWidth'(res.hum_word) * ProdWidth'(HumScale);
        temp_q    = div_full_scale(temp_prod);
        hum_q     = div_full_scale(hum_prod);
        if (res.crc_failed) begin
            temp_next   = '0;
            hum_next    = '0;
            status_next = StatusCrcError;
        end else begin
            temp_next   = 12'(temp_q) - TempOffset;
            hum_next    = hum_q[9:0];
            status_next = StatusOk;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            temp_reg   <= temp_next;
            hum_reg    <= hum_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = {2'b00, hum_reg, temp_reg};
    assign m_tuser[0] = status_reg;

    // Error results carry zero values
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && status_reg == StatusCrcError) |-> (temp_reg == '0 && hum_reg == '0))
        else $error("error result with nonzero values");

endmodule

>>> hdl/humidity_temp_frame_decoder_unit.sv
// Result: the sixth byte of a frame goes through input, frame and output registers to m_.
// One byte per cycle unless stalled; input, frame and output registers hold one each.
// The frame stage stalls only its final byte, while its full result register is not taken.
// Reset: synchronous, active-low aresetn; position returns to the first byte, CRC to 0xFF,
// and all valid flags clear.
module humidity_temp_frame_decoder_unit
    import htfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [11:0] temperature_tenths, [21:12] humidity_tenths
    output logic [0:0]  m_tuser    // [0] status
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       frame_in_ready;
    logic       raw_valid;
    logic       raw_ready;
    frame_raw_t raw;

    assign s_tready = !in_valid_reg || frame_in_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
    end

    htfd_frame u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_byte   (in_byte_reg),
        .in_start  (in_start_reg),
        .in_ready  (frame_in_ready),
        .res_valid (raw_valid),
        .res_ready (raw_ready),
        .res       (raw)
    );

    htfd_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (raw_valid),
        .res_ready (raw_ready),
        .res       (raw),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import htfd_pkg::*;

    localparam int unsigned FullScale  = 65535;
    localparam int unsigned PhaseItems = 550;
    localparam int unsigned HoldCycles = 400;
    localparam int unsigned CycleLimit = 200000;

    // One byte request toward the decoder
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } sensor_byte_t;

    // One decoded measurement
    typedef struct packed {
        logic [11:0] temp;
        logic [9:0]  hum;
        logic        status;
    } reading_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic [0:0]  s_tuser;   // [0] frame_start
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [11:0] temperature_tenths, [21:12] humidity_tenths
    logic [0:0]  m_tuser;   // [0] status

    humidity_temp_frame_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sensor_byte_t byte_feed[$];
    reading_t     readings_due[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    logic        byte_taken    = 1'b0;
    logic        rx_hold_arm   = 1'b0;
    logic        rx_hold_used  = 1'b0;
    int unsigned rx_hold_left  = 0;

    // Decoder shadow state
    logic [2:0]  frame_pos = PosTempHi;
    logic [7:0]  crc_acc   = CrcInit;
    logic [15:0] temp_raw  = '0;
    logic [7:0]  hum_hi    = '0;
    logic [7:0]  hum_lo    = '0;
    logic        crc_bad   = 1'b0;

    initial begin
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
    end

    always #4 aclk = ~aclk;

    // CRC-8, poly 0x31, MSB first
    function automatic logic [7:0] crc_shift_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc_shift_byte(crc_shift_byte(CrcInit, w[15:8]), w[7:0]);
    endfunction

    // Track one accepted byte; queue a reading when a frame closes
    task automatic decode_byte(input logic [7:0] b, input logic start);
        logic [2:0]  pos;
        reading_t    r;
        int unsigned t_scaled;
        int unsigned h_scaled;
        pos = frame_pos;
        if (start || pos > PosHumCrc) begin
            pos = PosTempHi;
        end
        case (pos)
            PosTempHi: begin
                crc_bad  = 1'b0;
                crc_acc  = crc_shift_byte(CrcInit, b);
                temp_raw = {b, 8'h00};
            end
            PosTempLo: begin
                crc_acc       = crc_shift_byte(crc_acc, b);
                temp_raw[7:0] = b;
            end
            PosTempCrc: begin
                if (b != crc_acc) crc_bad = 1'b1;
            end
            PosHumHi: begin
                crc_acc = crc_shift_byte(CrcInit, b);
                hum_hi  = b;
            end
            PosHumLo: begin
                crc_acc = crc_shift_byte(crc_acc, b);
                hum_lo  = b;
            end
            default: begin
                if (b != crc_acc) crc_bad = 1'b1;
                if (crc_bad) begin
                    r = '{temp: 12'd0, hum: 10'd0, status: StatusCrcError};
                end else begin
                    // truncating division, offset applied after scaling
                    t_scaled = (int'(TempScale) * int'(temp_raw)) / FullScale;
                    h_scaled = (int'(HumScale) * int'({hum_hi, hum_lo})) / FullScale;
                    r.temp   = 12'(t_scaled - int'(TempOffset));
                    r.hum    = 10'(h_scaled);
                    r.status = StatusOk;
                end
                readings_due.push_back(r);
            end
        endcase
        frame_pos = (pos == PosHumCrc) ? PosTempHi : pos + 3'd1;
    endtask

    // Queue a six-byte frame; flip masks corrupt the CRC bytes
    task automatic add_frame(input logic [15:0] t, input logic [15:0] h, input logic start,
                             input logic [7:0] t_flip, input logic [7:0] h_flip);
        byte_feed.push_back('{data: t[15:8], start: start});
        byte_feed.push_back('{data: t[7:0], start: 1'b0});
        byte_feed.push_back('{data: word_crc(t) ^ t_flip, start: 1'b0});
        byte_feed.push_back('{data: h[15:8], start: 1'b0});
        byte_feed.push_back('{data: h[7:0], start: 1'b0});
        byte_feed.push_back('{data: word_crc(h) ^ h_flip, start: 1'b0});
    endtask

    function automatic logic [15:0] pick_raw();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 16'h0000;
        if (r < 20) return 16'hFFFF;
        return 16'($urandom());
    endfunction

    // Mostly well-formed frames, some corrupted, some broken bursts
    task automatic fill_random(input int unsigned n);
        int unsigned added;
        int unsigned len;
        logic [7:0]  t_flip;
        logic [7:0]  h_flip;
        added = 0;
        while (added < n) begin
            if ($urandom_range(99) < 85) begin
                t_flip = ($urandom_range(9) == 0) ? 8'(1 << $urandom_range(7)) : 8'h00;
                h_flip = ($urandom_range(9) == 0) ? 8'(1 << $urandom_range(7)) : 8'h00;
                add_frame(pick_raw(), pick_raw(), 1'($urandom_range(1)), t_flip, h_flip);
                added += 6;
            end else begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    byte_feed.push_back('{data: 8'($urandom()), start: 1'($urandom_range(1))});
                end
                added += len;
            end
        end
    endtask

    // Hold the sender until all queued bytes are taken and all readings are back
    task automatic drain();
        while (byte_feed.size() != 0 || s_tvalid) @(posedge aclk);
        while (readings_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Byte driver: valid holds until the request is taken
    always @(negedge aclk) begin : drive_bytes
        sensor_byte_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || byte_taken) begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = byte_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.data;
                s_tuser  <= it.start;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result ready: random stalls plus one long hold-off
    always @(negedge aclk) begin : drive_ready
        if (rx_hold_arm && !rx_hold_used) begin
            rx_hold_used = 1'b1;
            rx_hold_left = HoldCycles;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Predict on accepted bytes, compare accepted readings
    always @(posedge aclk) begin : watch
        reading_t want;
        reading_t got;
        byte_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            decode_byte(s_tdata, s_tuser[0]);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = '{temp: m_tdata[11:0], hum: m_tdata[21:12], status: m_tuser[0]};
            if (readings_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected reading: temp=%0d hum=%0d status=%0b",
                             $signed(got.temp), got.hum, got.status);
                end
            end else begin
                want = readings_due.pop_front();
                if (got !== want || m_tdata[23:22] !== 2'b00) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("reading mismatch: exp temp=%0d hum=%0d status=%0b, got temp=%0d hum=%0d status=%0b pad=%b",
                                 $signed(want.temp), want.hum, want.status,
                                 $signed(got.temp), got.hum, got.status, m_tdata[23:22]);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : run
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Phase 1: sender idles 30%, receiver 60%
        send_idle_pct = 30;
        recv_idle_pct = 60;
        add_frame(16'h0000, 16'h0000, 1'b1, 8'h00, 8'h00);   // coldest, driest
        add_frame(16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 8'h00);   // hottest, wettest; no start flag
        byte_feed.push_back('{data: 8'hBE, start: 1'b1});     // partial frame, dropped
        byte_feed.push_back('{data: 8'hEF, start: 1'b0});
        add_frame(16'h6666, 16'h8000, 1'b1, 8'h01, 8'h00);   // bad temperature CRC
        add_frame(16'h1234, 16'hABCD, 1'b1, 8'h00, 8'h80);   // bad humidity CRC
        fill_random(PhaseItems);
        drain();

        // Phase 2: the other way round
        send_idle_pct = 60;
        recv_idle_pct = 30;
        fill_random(PhaseItems);
        drain();

        // Phase 3: no idling, with a long receiver hold-off up front
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_random(PhaseItems);
        rx_hold_arm = 1'b1;
        drain();

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/htfd_pkg.sv
hdl/htfd_frame.sv
hdl/htfd_scale.sv
hdl/humidity_temp_frame_decoder_unit.sv
test/tb_top.sv
